// File: rtl/locd_pkg.sv
package locd_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_BITS  = 48;
   localparam int SLOT_BITS = $clog2(ENTRIES);
   localparam int RANK_BITS = $clog2(ENTRIES);

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   localparam logic [RANK_BITS-1:0] RANK_OLDEST = RANK_BITS'(ENTRIES - 1);

   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [RANK_BITS-1:0] rank_type;
   typedef logic [ENTRIES-1:0]   slot_vec_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic commit;
   } locd_cmd_type;

   // lowest set bit of a slot vector, zero when none is set
   function automatic slot_type lowest_slot(slot_vec_type v);
      slot_type idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SLOT_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// File: rtl/locd_req_if.sv
interface locd_req_if import locd_pkg::*;;
   logic    valid;
   logic    ready;
   logic    command;
   key_type key;

   modport source (output valid, output command, output key, input ready);
   modport sink (input valid, input command, input key, output ready);
endinterface

// File: rtl/locd_rsp_if.sv
interface locd_rsp_if import locd_pkg::*;;
   logic     valid;
   logic     ready;
   logic     hit;
   slot_type slot;
   logic     evicted;

   modport source (output valid, output hit, output slot, output evicted, input ready);
   modport sink (input valid, input hit, input slot, input evicted, output ready);
endinterface

// File: rtl/locd_ctrl.sv
module locd_ctrl import locd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output locd_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.load     = 1'b0;
      cmd.commit   = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait here while the previous result is still unread
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over an unread result");

   a_load_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted beat not taken into execution");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC))
      else $error("result raised outside execution");

endmodule

// File: rtl/locd_datapath.sv
module locd_datapath import locd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  locd_cmd_type cmd,
   input  logic         req_command,
   input  key_type      req_key,
   output logic         rsp_hit,
   output slot_type     rsp_slot,
   output logic         rsp_evicted
);

   logic         cmd_ff;
   key_type      key_ff;
   slot_vec_type slot_valid_ff, slot_valid_in;
   key_type      slot_key_ff [ENTRIES];
   rank_type     slot_rank_ff [ENTRIES];
   rank_type     slot_rank_in [ENTRIES];
   logic         hit_ff, hit_in;
   slot_type     slot_ff, slot_in;
   logic         evicted_ff, evicted_in;

   slot_vec_type match;
   slot_vec_type oldest;
   logic         any_match;
   logic         any_free;
   slot_type     match_pos;
   slot_type     pos;
   rank_type     old_rank;
   logic         age_all;
   logic         update;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = slot_valid_ff[i] && (slot_key_ff[i] == key_ff);
         oldest[i] = (slot_rank_ff[i] == RANK_OLDEST);
      end
   end

   assign any_match = |match;
   assign any_free  = !(&slot_valid_ff);
   assign match_pos = lowest_slot(match);

   always_comb begin
      if (cmd_ff == CMD_LOOKUP) begin
         pos      = match_pos;
         old_rank = slot_rank_ff[match_pos];
         age_all  = 1'b0;
         update   = any_match;
      end else begin
         pos      = any_free ? lowest_slot(~slot_valid_ff) : lowest_slot(oldest);
         old_rank = RANK_OLDEST;
         // a free slot means every valid entry grows one older
         age_all  = any_free;
         update   = 1'b1;
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_rank_in[i] = slot_rank_ff[i];
         if (update) begin
            if (SLOT_BITS'(i) == pos) begin
               slot_rank_in[i] = '0;
            end else if (slot_valid_ff[i] && (age_all || (slot_rank_ff[i] < old_rank))) begin
               slot_rank_in[i] = slot_rank_ff[i] + 1'b1;
            end
         end
      end
      if (cmd_ff == CMD_INSERT) begin
         slot_valid_in[pos] = 1'b1;
      end
   end

   always_comb begin
      hit_in     = (cmd_ff == CMD_LOOKUP) && any_match;
      slot_in    = ((cmd_ff == CMD_LOOKUP) && !any_match) ? '0 : pos;
      evicted_in = (cmd_ff == CMD_INSERT) && !any_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_rank_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         slot_valid_ff <= slot_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_rank_ff[i] <= slot_rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
      end
      if (cmd.commit) begin
         hit_ff     <= hit_in;
         slot_ff    <= slot_in;
         evicted_ff <= evicted_in;
         if (cmd_ff == CMD_INSERT) begin
            slot_key_ff[pos] <= key_ff;
         end
      end
   end

   assign rsp_hit     = hit_ff;
   assign rsp_slot    = slot_ff;
   assign rsp_evicted = evicted_ff;

   a_insert_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (cmd_ff == CMD_INSERT)) |=> slot_valid_ff[slot_ff])
      else $error("inserted slot not marked valid");

   a_hit_xor_evict: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !(hit_ff && evicted_ff))
      else $error("hit and eviction reported together");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && any_free) |=> !evicted_ff)
      else $error("eviction while a free slot existed");

endmodule

// File: rtl/lru_object_cache_directory_core.sv
// fully associative lru directory of sixteen slots, 48-bit key tags
// req channel: one beat carries command (0 lookup, 1 insert) and key
// rsp channel: one beat per request with hit, slot and evicted
// lookup: lowest valid slot with an equal key; on a hit it becomes most recent
// lookup miss: hit 0, slot 0, evicted 0, nothing changes
// insert: lowest free slot, else the least recent slot (evicted 1);
// the written slot becomes most recent, duplicate keys are not checked
// the request beat is registered, then the result is registered on commit
// in the execute state; a new request is taken only once the previous one
// has left the single compare-and-update pass over the slot flops
// a new request is taken while the previous result still waits, but the
// next result is held back until the earlier one has been read, so a
// stalled receiver holds the block after at most one further request
// reset (synchronous, active high) invalidates every slot and empties the
// result register; requests are taken in the very next cycle
module lru_object_cache_directory_core import locd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   locd_req_if.sink   req,
   locd_rsp_if.source rsp
);

   locd_cmd_type cmd;

   locd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   locd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_command (req.command),
      .req_key     (req.key),
      .rsp_hit     (rsp.hit),
      .rsp_slot    (rsp.slot),
      .rsp_evicted (rsp.evicted)
   );

endmodule
